@@ design/mnr_pkg.sv @@
package mnr_pkg;

	localparam int FIELD_W = 31;
	localparam int DATA_WIDTH_DEF = 31;

	typedef struct packed {
		logic [FIELD_W-1:0] numerator;
		logic [FIELD_W-1:0] denominator;
	} in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] whole_part;
		logic [FIELD_W-1:0] frac_numerator;
		logic [FIELD_W-1:0] frac_denominator;
		logic               divide_error;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_GCD,
		ST_FN_START,
		ST_FN_WAIT,
		ST_FD_START,
		ST_FD_WAIT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		DIV_NUM_BY_DEN,
		DIV_REM_BY_G,
		DIV_DEN_BY_G
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     save_whole;
		logic     gcd_start;
		logic     gcd_step;
		logic     save_fn;
		logic     save_fd;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic den_zero;
		logic div_busy;
		logic rem_zero;
		logic gcd_eq;
	} sts_t;

endpackage

@@ design/mnr_divider.sv @@
module mnr_divider #(
	parameter int DW = mnr_pkg::DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient,
	output logic [DW-1:0] remainder
);
	localparam int CW = $clog2(DW);

	logic [DW-1:0] q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic          ge;

	// restoring division, one quotient bit per cycle
	assign trial = {r_q, q_q[DW-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DW - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DW-2:0], ge};
			r_q <= ge ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = q_q;
	assign remainder = r_q;

endmodule

@@ design/mnr_datapath.sv @@
module mnr_datapath #(
	parameter int DW = mnr_pkg::DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mnr_pkg::in_t  in_data,
	input  mnr_pkg::cmd_t cmd,
	output mnr_pkg::sts_t sts,
	output mnr_pkg::out_t out_data
);
	import mnr_pkg::*;

	localparam int KW = $clog2(DW + 1);

	logic [DW-1:0] num_q, den_q, whole_q, rem_q, fn_q, fd_q;
	logic [DW-1:0] a_q, b_q;
	logic [KW-1:0] k_q;
	logic [DW-1:0] gcd_val;
	logic [DW-1:0] div_dividend, div_divisor, div_quot, div_rem;
	logic          div_busy;
	out_t          res;
	out_t          out_q;

	assign gcd_val = DW'(a_q << k_q);

	always_comb begin
		unique case (cmd.div_sel)
			DIV_NUM_BY_DEN: begin
				div_dividend = num_q;
				div_divisor  = den_q;
			end
			DIV_REM_BY_G: begin
				div_dividend = rem_q;
				div_divisor  = gcd_val;
			end
			DIV_DEN_BY_G: begin
				div_dividend = den_q;
				div_divisor  = gcd_val;
			end
			default: begin
				div_dividend = num_q;
				div_divisor  = den_q;
			end
		endcase
	end

	mnr_divider #(.DW(DW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= DW'(in_data.numerator);
			den_q <= DW'(in_data.denominator);
		end
		if (cmd.save_whole) begin
			whole_q <= div_quot;
			rem_q   <= div_rem;
		end
		if (cmd.save_fn)
			fn_q <= div_quot;
		if (cmd.save_fd)
			fd_q <= div_quot;
	end

	// binary gcd: common factors of two counted in k, odd parts reduced by subtraction
	always_ff @(posedge clk) begin
		if (cmd.gcd_start) begin
			a_q <= div_rem;
			b_q <= den_q;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
	end

	always_comb begin
		res = '0;
		if (den_q == '0) begin
			res.divide_error = 1'b1;
		end else if (rem_q == '0) begin
			res.whole_part       = FIELD_W'(whole_q);
			res.frac_denominator = FIELD_W'(1);
		end else begin
			res.whole_part       = FIELD_W'(whole_q);
			res.frac_numerator   = FIELD_W'(fn_q);
			res.frac_denominator = FIELD_W'(fd_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_q <= res;
	end

	assign sts.den_zero = (den_q == '0);
	assign sts.div_busy = div_busy;
	assign sts.rem_zero = (div_rem == '0);
	assign sts.gcd_eq   = (a_q == b_q);
	assign out_data     = out_q;

endmodule

@@ design/mnr_ctrl.sv @@
module mnr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mnr_pkg::sts_t sts,
	output mnr_pkg::cmd_t cmd
);
	import mnr_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DIV_NUM_BY_DEN;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV_START;
				end
			end
			ST_DIV_START: begin
				if (sts.den_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (!sts.div_busy) begin
					cmd.save_whole = 1'b1;
					if (sts.rem_zero) begin
						state_d = ST_FINISH;
					end else begin
						cmd.gcd_start = 1'b1;
						state_d       = ST_GCD;
					end
				end
			end
			ST_GCD: begin
				if (sts.gcd_eq)
					state_d = ST_FN_START;
				else
					cmd.gcd_step = 1'b1;
			end
			ST_FN_START: begin
				cmd.div_sel   = DIV_REM_BY_G;
				cmd.div_start = 1'b1;
				state_d       = ST_FN_WAIT;
			end
			ST_FN_WAIT: begin
				if (!sts.div_busy) begin
					cmd.save_fn = 1'b1;
					state_d     = ST_FD_START;
				end
			end
			ST_FD_START: begin
				cmd.div_sel   = DIV_DEN_BY_G;
				cmd.div_start = 1'b1;
				state_d       = ST_FD_WAIT;
			end
			ST_FD_WAIT: begin
				if (!sts.div_busy) begin
					cmd.save_fd = 1'b1;
					state_d     = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// previous item must have left the output register
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/mixed_number_reducer.sv @@
// schedule: one shared bit-serial divider is used up to three times per item, with the gcd
// stepping between its first and second use until both operands are equal; with zero remainder
// the result goes to finish after the first division, and with zero denominator no division runs
// throughput: one item at a time, the next is taken in the cycle after the result is loaded,
// even while that result still waits at the output
// reset: arst_n asynchronous, active low; clears controller state, output valid and divider busy state
module mixed_number_reducer #(
	parameter int DATA_WIDTH = mnr_pkg::DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mnr_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output mnr_pkg::out_t out_data
);
	import mnr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mnr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mnr_datapath #(.DW(DATA_WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

@@ design/mnr_checker.sv @@
module mnr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input mnr_pkg::out_t out_data
);

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	// error item carries all-zero fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_error |->
		out_data.whole_part == '0 && out_data.frac_numerator == '0 &&
		out_data.frac_denominator == '0)
		else $error("error item with non-zero fields");

	// reduced fraction is proper
	a_proper: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.divide_error |->
		out_data.frac_denominator != '0 &&
		out_data.frac_numerator < out_data.frac_denominator)
		else $error("fraction not proper");

	// exact division gives 0/1
	a_exact: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.divide_error && out_data.frac_numerator == '0 |->
		out_data.frac_denominator == 31'd1)
		else $error("exact division without unit denominator");

endmodule

bind mixed_number_reducer mnr_checker u_chk (.*);

@@ tb/sv/mixed_number_reducer_tb.sv @@
module mixed_number_reducer_tb;
	import mnr_pkg::*;

	localparam int unsigned MAXV         = 32'h7fff_ffff;
	localparam int          RANDOM_ITEMS = 700;
	localparam int          PAUSE_AT     = 420;
	localparam int          HOLD_AT      = 150;
	localparam int          HOLD_LEN     = 800;
	localparam int          QUIET_LO     = 520;
	localparam int          QUIET_HI     = 620;
	localparam int          TAIL_CYCLES  = 400;
	localparam int          CYCLE_LIMIT  = 1_500_000;
	localparam int          REPORT_MAX   = 10;

	typedef struct {
		logic [FIELD_W-1:0] numerator;
		logic [FIELD_W-1:0] denominator;
		bit                 typed;
		out_t               result;
	} fraction_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	out_t          mixed_expected[$];
	fraction_row_t fraction_rows[$];
	int            fail_count  = 0;
	int            cycle_count = 0;

	mixed_number_reducer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic out_t reduce_to_mixed(input in_t item);
		out_t             res;
		longint unsigned  n;
		longint unsigned  d;
		longint unsigned  r;
		longint unsigned  a;
		longint unsigned  b;
		longint unsigned  t;
		n = item.numerator;
		d = item.denominator;
		res = '0;
		if (d == 0) begin
			res.divide_error = 1'b1;
		end else begin
			r = n % d;
			res.whole_part = FIELD_W'(n / d);
			if (r == 0) begin
				res.frac_denominator = FIELD_W'(1);
			end else begin
				a = r;
				b = d;
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				res.frac_numerator   = FIELD_W'(r / a);
				res.frac_denominator = FIELD_W'(d / a);
			end
		end
		return res;
	endfunction

	function automatic int idle_cycles(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	function automatic in_t random_fraction();
		in_t         item;
		int unsigned pick;
		int unsigned g;
		int unsigned k;
		pick = $urandom_range(0, 99);
		item.numerator   = FIELD_W'($urandom());
		item.denominator = FIELD_W'($urandom());
		if (pick < 5) begin
			item.denominator = '0;
		end else if (pick < 12) begin
			item.numerator   = '0;
			item.denominator = FIELD_W'($urandom_range(1, MAXV));
		end else if (pick < 25) begin
			// exact multiple of a modest divisor
			g = $urandom_range(1, 65535);
			k = $urandom_range(0, MAXV / g);
			item.numerator   = FIELD_W'(g * k);
			item.denominator = FIELD_W'(g);
		end else if (pick < 50) begin
			// shared factor so the gcd is at least two
			g = $urandom_range(2, 46340);
			item.numerator   = FIELD_W'(g * $urandom_range(1, 46340));
			item.denominator = FIELD_W'(g * $urandom_range(1, 46340));
		end else if (pick < 70) begin
			item.numerator   = FIELD_W'($urandom_range(0, 1023));
			item.denominator = FIELD_W'($urandom_range(1, 255));
		end
		return item;
	endfunction

	task automatic add_row(input int unsigned num, input int unsigned den, input bit typed,
			input int unsigned whole, input int unsigned fn, input int unsigned fd,
			input bit err);
		fraction_row_t row;
		row.numerator                = FIELD_W'(num);
		row.denominator              = FIELD_W'(den);
		row.typed                    = typed;
		row.result.whole_part        = FIELD_W'(whole);
		row.result.frac_numerator    = FIELD_W'(fn);
		row.result.frac_denominator  = FIELD_W'(fd);
		row.result.divide_error      = err;
		fraction_rows.push_back(row);
	endtask

	task automatic offer_fraction(input in_t item, input bit typed, input out_t typed_result,
			input bit quiet);
		int gap;
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		if (typed)
			mixed_expected.push_back(typed_result);
		else
			mixed_expected.push_back(reduce_to_mixed(item));
		gap = idle_cycles(quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		in_t item;
		// zero denominator
		add_row(0, 0, 1, 0, 0, 0, 1);
		add_row(MAXV, 0, 1, 0, 0, 0, 1);
		add_row(1, 0, 1, 0, 0, 0, 1);
		// zero numerator
		add_row(0, 1, 1, 0, 0, 1, 0);
		add_row(0, MAXV, 1, 0, 0, 1, 0);
		// exact division
		add_row(MAXV, 1, 1, MAXV, 0, 1, 0);
		add_row(MAXV, MAXV, 1, 1, 0, 1, 0);
		add_row(1, 1, 1, 1, 0, 1, 0);
		add_row(12, 4, 1, 3, 0, 1, 0);
		add_row(32'h4000_0000, 32'h0000_8000, 1, 32'h0000_8000, 0, 1, 0);
		// proper fractions and mixed numbers
		add_row(1, MAXV, 1, 0, 1, MAXV, 0);
		add_row(MAXV - 1, MAXV, 1, 0, MAXV - 1, MAXV, 0);
		add_row(1, 2, 1, 0, 1, 2, 0);
		add_row(MAXV, 2, 1, 32'h3fff_ffff, 1, 2, 0);
		add_row(MAXV, MAXV - 1, 1, 1, 1, MAXV - 1, 0);
		add_row(6, 8, 0, 0, 0, 0, 0);
		add_row(7, 3, 0, 0, 0, 0, 0);
		add_row(100, 75, 0, 0, 0, 0, 0);
		add_row(2, MAXV, 0, 0, 0, 0, 0);
		add_row(32'h5555_5555, 32'h2aaa_aaaa, 0, 0, 0, 0, 0);
		add_row(32'h2aaa_aaaa, 32'h5555_5555, 0, 0, 0, 0, 0);
		add_row(32'h3000_0000, 32'h4000_0000, 0, 0, 0, 0, 0);
		// consecutive fibonacci numbers give the longest euclid run
		add_row(1836311903, 1134903170, 0, 0, 0, 0, 0);
		add_row(1134903170, 1836311903, 0, 0, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (fraction_rows[i]) begin
			item.numerator   = fraction_rows[i].numerator;
			item.denominator = fraction_rows[i].denominator;
			offer_fraction(item, fraction_rows[i].typed, fraction_rows[i].result, 1'b0);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == PAUSE_AT) begin
				in_valid <= 1'b0;
				while (mixed_expected.size() != 0) @(posedge clk);
			end
			offer_fraction(random_fraction(), 1'b0, '0, i >= QUIET_LO && i < QUIET_HI);
		end
		in_valid <= 1'b0;

		while (mixed_expected.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && mixed_expected.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result side: ready drops after some items and waits on the next valid
	initial begin
		int taken;
		taken = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			if (taken == HOLD_AT) begin
				// long hold-off so the block fills and stalls its input
				out_ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else if (!(taken >= QUIET_LO && taken < QUIET_HI) && $urandom_range(0, 1)) begin
				out_ready <= 1'b0;
				do @(posedge clk); while (!out_valid);
				repeat (idle_cycles(1'b0)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (mixed_expected.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected item: whole %0d frac %0d/%0d err %0b",
						out_data.whole_part, out_data.frac_numerator,
						out_data.frac_denominator, out_data.divide_error);
			end else begin
				want = mixed_expected.pop_front();
				if (out_data.whole_part !== want.whole_part
						|| out_data.frac_numerator !== want.frac_numerator
						|| out_data.frac_denominator !== want.frac_denominator
						|| out_data.divide_error !== want.divide_error) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("mismatch: want %0d %0d/%0d err %0b, got %0d %0d/%0d err %0b",
							want.whole_part, want.frac_numerator, want.frac_denominator,
							want.divide_error, out_data.whole_part, out_data.frac_numerator,
							out_data.frac_denominator, out_data.divide_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
